/* design/bat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bat_pkg: shared types and constants for the bond address table
// Table geometry, action codes, sequencer states and channel structs.
// ----------------------------------------------------------------------------
package bat_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 8;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 48;
	localparam int COUNT_OUT_W = 4;

	typedef enum logic [2:0] {
		ACT_ADD      = 3'd0,
		ACT_REMOVE   = 3'd1,
		ACT_LOOKUP   = 3'd2,
		ACT_CLEAR    = 3'd3,
		ACT_ENTER    = 3'd4,
		ACT_EXIT     = 3'd5,
		ACT_SET_PEND = 3'd6,
		ACT_CONFIRM  = 3'd7
	} bat_action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_APPEND
	} bat_state_t;

	// input item
	typedef struct packed {
		logic [2:0]        action;
		logic [ADDR_W-1:0] address;
	} bat_cmd_t;

	// result item
	typedef struct packed {
		logic                   ok;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   pairing_on;
		logic                   pending_ready;
	} bat_rsp_t;

	// sequencer to entry store
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic             from_rd;   // write data is the read entry, else the key
		logic [IDX_W-1:0] raddr;
	} bat_store_ctl_t;

	// low bits of the fill count for the result field
	function automatic logic [COUNT_OUT_W-1:0] count_field(input logic [CNT_W-1:0] c);
		logic [CNT_W+COUNT_OUT_W-1:0] w;
		w = {{COUNT_OUT_W{1'b0}}, c};
		return w[COUNT_OUT_W-1:0];
	endfunction

endpackage

/* design/bat_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bat_store: address entry array with the shared comparator
// One read port feeds the key compare and the compaction write path.
// ----------------------------------------------------------------------------
module bat_store
	import bat_pkg::*;
(
	input  logic                 clk,
	input  bat_store_ctl_t       ctl,
	input  logic [ADDR_W-1:0]    key,
	output logic                 match
);

	logic [ADDR_W-1:0] entries_q [TABLE_DEPTH];
	logic [ADDR_W-1:0] rdata;
	logic [ADDR_W-1:0] wdata;

	// single read port, shared comparator
	assign rdata = entries_q[ctl.raddr];
	assign match = (rdata == key);
	assign wdata = ctl.from_rd ? rdata : key;

	// single write port, no reset on payload
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			entries_q[ctl.waddr] <= wdata;
		end
	end

endmodule

/* design/bat_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bat_ctrl: operation sequencer for the bond address table
// Scans entries one per cycle, compacts one per cycle, holds flags and count.
// ----------------------------------------------------------------------------
module bat_ctrl
	import bat_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bat_cmd_t          cmd,
	output logic              busy,
	output logic              done,
	output bat_rsp_t          rsp,
	output bat_store_ctl_t    store_ctl,
	output logic [ADDR_W-1:0] key,
	input  logic              match
);

	bat_state_t        state_q, state_d;
	logic [IDX_W-1:0]  ptr_q, ptr_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              pairing_q, pairing_d;
	logic              pend_q, pend_d;
	logic              ok_q, ok_d;
	logic              done_q;
	logic              finish;
	logic              accept;
	bat_action_t       act_q;
	logic [ADDR_W-1:0] key_q;
	logic [ADDR_W-1:0] pend_addr_q;

	logic [CNT_W-1:0]  ptr_ext;
	logic [CNT_W-1:0]  ptr_inc;
	logic              full;
	logic              hit;
	logic              miss_end;

	assign accept  = start && (state_q == ST_IDLE);
	assign ptr_ext = CNT_W'(ptr_q);
	assign ptr_inc = ptr_ext + CNT_W'(1);
	assign full    = (count_q == CNT_W'(TABLE_DEPTH));
	assign hit     = (ptr_ext < count_q) && match;
	assign miss_end = (ptr_ext >= count_q) || (!match && (ptr_inc >= count_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (bat_action_t'(cmd.action)) inside
						ACT_ADD, ACT_REMOVE, ACT_LOOKUP: state_d = ST_SCAN;
						ACT_CONFIRM: begin
							if (pairing_q && pend_q) state_d = ST_SCAN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = (act_q == ACT_REMOVE) ? ST_SHIFT : ST_IDLE;
				end else if (miss_end) begin
					if (act_q == ACT_ADD || act_q == ACT_CONFIRM) begin
						state_d = full ? ST_SHIFT : ST_APPEND;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SHIFT: begin
				if (ptr_inc >= count_q) begin
					state_d = (act_q == ACT_REMOVE) ? ST_IDLE : ST_APPEND;
				end
			end
			ST_APPEND: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		ptr_d     = ptr_q;
		count_d   = count_q;
		pairing_d = pairing_q;
		pend_d    = pend_q;
		ok_d      = ok_q;
		finish    = 1'b0;
		store_ctl = '{we: 1'b0, waddr: ptr_q, from_rd: 1'b0, raddr: ptr_q};
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ptr_d = '0;
					ok_d  = 1'b1;
					case (bat_action_t'(cmd.action)) inside
						ACT_CLEAR: begin
							count_d = '0;
							finish  = 1'b1;
						end
						ACT_ENTER: begin
							pairing_d = 1'b1;
							finish    = 1'b1;
						end
						ACT_EXIT: begin
							pairing_d = 1'b0;
							pend_d    = 1'b0;
							finish    = 1'b1;
						end
						ACT_SET_PEND: begin
							pend_d = 1'b1;
							finish = 1'b1;
						end
						ACT_CONFIRM: begin
							if (pairing_q && pend_q) begin
								pairing_d = 1'b0;
								pend_d    = 1'b0;
							end else begin
								ok_d   = 1'b0;
								finish = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				// one entry compared per cycle
				if (hit) begin
					if (act_q != ACT_REMOVE) finish = 1'b1;
				end else if (miss_end) begin
					if (act_q == ACT_ADD || act_q == ACT_CONFIRM) begin
						ptr_d = full ? '0 : IDX_W'(count_q);
					end else begin
						ok_d   = 1'b0;
						finish = 1'b1;
					end
				end else begin
					ptr_d = ptr_q + IDX_W'(1);
				end
			end
			ST_SHIFT: begin
				// move entry ptr+1 down to ptr
				store_ctl.raddr = ptr_q + IDX_W'(1);
				if (ptr_inc < count_q) begin
					store_ctl.we      = 1'b1;
					store_ctl.from_rd = 1'b1;
					ptr_d             = ptr_q + IDX_W'(1);
				end else if (act_q == ACT_REMOVE) begin
					count_d = count_q - CNT_W'(1);
					finish  = 1'b1;
				end
			end
			ST_APPEND: begin
				store_ctl.we = 1'b1;
				if (!full) count_d = count_q + CNT_W'(1);
				finish = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ptr_q     <= '0;
			count_q   <= '0;
			pairing_q <= 1'b0;
			pend_q    <= 1'b0;
			ok_q      <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			ptr_q     <= ptr_d;
			count_q   <= count_d;
			pairing_q <= pairing_d;
			pend_q    <= pend_d;
			ok_q      <= ok_d;
			done_q    <= finish;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= bat_action_t'(cmd.action);
			key_q <= (bat_action_t'(cmd.action) == ACT_CONFIRM) ? pend_addr_q : cmd.address;
			if (bat_action_t'(cmd.action) == ACT_SET_PEND) pend_addr_q <= cmd.address;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign key  = key_q;
	assign rsp  = '{ok: ok_q, entry_count: count_field(count_q),
		pairing_on: pairing_q, pending_ready: pend_q};

endmodule

/* design/bond_address_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bond_address_table_top: insertion-ordered device address table
// Eight-entry address table with pairing mode and one pending address.
//
//   channel   ports               handshake
//   command   cmd (bat_cmd_t)     start high while busy low
//   result    rsp (bat_rsp_t)     done high for one cycle, no backpressure
//
// Flag, clear and refused confirm actions finish on acceptance. Lookup scans
// one entry per cycle. Compaction moves one entry per cycle plus a closing
// step, and add ends with an append step; the longest operation is a new
// address added to a full table, which scans, compacts and appends. The scan
// and compaction share one read port of the entry array, which also feeds the
// comparator. The result follows in the cycle after the last step, with busy
// already low. Reset empties the table and clears pairing and pending flags.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module bond_address_table_top
	import bat_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  bat_cmd_t cmd,
	output logic     busy,
	output logic     done,
	output bat_rsp_t rsp
);

	bat_store_ctl_t    store_ctl;
	logic [ADDR_W-1:0] key;
	logic              match;

	// sequencer
	bat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.store_ctl (store_ctl),
		.key       (key),
		.match     (match)
	);

	// entry array and comparator
	bat_store u_store (
		.clk   (clk),
		.ctl   (store_ctl),
		.key   (key),
		.match (match)
	);

endmodule
